/* hw/rtl/assert_macros.svh */
// Assertion macros used by the controller of the ellipse plotter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MEP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MEP_ASSERT(label, clk, rst, prop, msg)
`define MEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/mep_pkg.sv */
// Types, constants and command codes of the midpoint ellipse plotter.
package mep_pkg;

   localparam int COORD_BITS  = 8;
   localparam int SIZE_BITS   = 7;
   localparam int SIZE_LIMIT  = 63;
   localparam int MAX_RES     = 63;
   localparam int HALF_BITS   = 5;
   localparam int STEP_BITS   = 6;
   localparam int CNT_BITS    = 6;
   localparam int SQ_BITS     = 10;
   localparam int TERM_BITS   = 18;
   localparam int MUL_A_BITS  = 17;
   localparam int MUL_B_BITS  = 10;
   localparam int PROD_BITS   = 24;
   localparam int DEC_BITS    = 26;
   localparam int REQ_BITS    = 32;
   localparam int RSP_BITS    = 40;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL_AA,
      OP_MUL_BB,
      OP_MUL_A2B,
      OP_INIT,
      OP_R1_STEP,
      OP_R2_MX,
      OP_R2_MY,
      OP_R2_MA2Y,
      OP_R2_MA2B2,
      OP_R2_FIN,
      OP_R2_STEP
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_A,
      S_SQ_B,
      S_A2B,
      S_INIT,
      S_R1,
      S_R2_MX,
      S_R2_MY,
      S_R2_MA2Y,
      S_R2_MA2B2,
      S_R2_FIN,
      S_R2
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_size;
      logic r1_more;
      logic y_more;
      logic slot_free;
   } dp_status_type;

endpackage

/* hw/rtl/mep_datapath.sv */
// Datapath of the ellipse plotter: decision terms, shared multiplier and output register.
module mep_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mep_pkg::dp_cmd_type               cmd,
   output mep_pkg::dp_status_type            status,
   input  logic [mep_pkg::REQ_BITS-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mep_pkg::RSP_BITS-1:0]      rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int CB = mep_pkg::COORD_BITS;
   localparam int DB = mep_pkg::DEC_BITS;
   localparam int TB = mep_pkg::TERM_BITS;

   // Command fields.
   logic [CB-1:0]                       req_cx;
   logic [CB-1:0]                       req_cy;
   logic signed [mep_pkg::SIZE_BITS-1:0] req_w;
   logic signed [mep_pkg::SIZE_BITS-1:0] req_h;
   logic [mep_pkg::SIZE_BITS-1:0]       w_abs;
   logic [mep_pkg::SIZE_BITS-1:0]       h_abs;
   logic [mep_pkg::SIZE_BITS-1:0]       w_mag;
   logic [mep_pkg::SIZE_BITS-1:0]       h_mag;
   logic [mep_pkg::HALF_BITS-1:0]       a_load;
   logic [mep_pkg::HALF_BITS-1:0]       b_load;
   logic [CB-1:0]                       cx_load;
   logic [CB-1:0]                       cy_load;

   // Walk state.
   logic [CB-1:0]                       centre_x_ff, centre_x_in;
   logic [CB-1:0]                       centre_y_ff, centre_y_in;
   logic [mep_pkg::HALF_BITS-1:0]       a_ff, a_in;
   logic [mep_pkg::HALF_BITS-1:0]       b_ff, b_in;
   logic [mep_pkg::SQ_BITS-1:0]         a2_ff, a2_in;
   logic [mep_pkg::SQ_BITS-1:0]         b2_ff, b2_in;
   logic [mep_pkg::STEP_BITS-1:0]       x_ff, x_in;
   logic [mep_pkg::STEP_BITS-1:0]       y_ff, y_in;
   logic signed [TB-1:0]                tx_ff, tx_in;
   logic signed [TB-1:0]                ty_ff, ty_in;
   logic signed [DB-1:0]                d_ff, d_in;
   logic [mep_pkg::PROD_BITS-1:0]       prod_ff, prod_in;
   logic [mep_pkg::CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [mep_pkg::CNT_BITS:0]          cnt_next;
   logic                                red_ff, red_in;
   logic                                green_ff, green_in;

   // Multiplier.
   logic [mep_pkg::MUL_A_BITS-1:0]                     mul_a;
   logic [mep_pkg::MUL_B_BITS-1:0]                     mul_b;
   logic [mep_pkg::MUL_A_BITS+mep_pkg::MUL_B_BITS-1:0] mul_full;
   logic [mep_pkg::STEP_BITS-1:0]                      y_dec;

   // Decision increments.
   logic signed [DB-1:0] a2_d, b2_d, tx_d, ty_d, prod_d;
   logic signed [DB-1:0] r1_dx, r1_dy, r2_dx, r2_dy, init_d;
   logic signed [TB-1:0] a2_t, b2_t;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mep_pkg::RSP_BITS-1:0]        rsp_data_ff, rsp_data_in;
   logic                                rsp_last_ff, rsp_last_in;

   assign req_cx = req_tdata[7:0];
   assign req_cy = req_tdata[15:8];
   assign req_w  = req_tdata[22:16];
   assign req_h  = req_tdata[29:23];

   // A negative size shifts the corner back by its magnitude.
   always_comb begin
      w_abs  = req_w[mep_pkg::SIZE_BITS-1] ? mep_pkg::SIZE_BITS'(-req_w) : req_w;
      h_abs  = req_h[mep_pkg::SIZE_BITS-1] ? mep_pkg::SIZE_BITS'(-req_h) : req_h;
      w_mag  = (w_abs > mep_pkg::SIZE_BITS'(mep_pkg::SIZE_LIMIT)) ?
               mep_pkg::SIZE_BITS'(mep_pkg::SIZE_LIMIT) : w_abs;
      h_mag  = (h_abs > mep_pkg::SIZE_BITS'(mep_pkg::SIZE_LIMIT)) ?
               mep_pkg::SIZE_BITS'(mep_pkg::SIZE_LIMIT) : h_abs;
      a_load = w_mag[mep_pkg::HALF_BITS:1];
      b_load = h_mag[mep_pkg::HALF_BITS:1];
      cx_load = req_w[mep_pkg::SIZE_BITS-1] ? (req_cx - CB'(w_mag)) : req_cx;
      cy_load = req_h[mep_pkg::SIZE_BITS-1] ? (req_cy - CB'(h_mag)) : req_cy;
   end

   assign y_dec = y_ff - mep_pkg::STEP_BITS'(1);

   // One multiplier shared by the setup and region-two entry sequences.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         mep_pkg::OP_MUL_AA: begin
            mul_a = mep_pkg::MUL_A_BITS'(a_ff);
            mul_b = mep_pkg::MUL_B_BITS'(a_ff);
         end
         mep_pkg::OP_MUL_BB: begin
            mul_a = mep_pkg::MUL_A_BITS'(b_ff);
            mul_b = mep_pkg::MUL_B_BITS'(b_ff);
         end
         mep_pkg::OP_MUL_A2B: begin
            mul_a = mep_pkg::MUL_A_BITS'(a2_ff);
            mul_b = mep_pkg::MUL_B_BITS'(b_ff);
         end
         mep_pkg::OP_R2_MX: begin
            mul_a = tx_ff[mep_pkg::MUL_A_BITS-1:0];
            mul_b = mep_pkg::MUL_B_BITS'({x_ff, 1'b1});
         end
         mep_pkg::OP_R2_MY: begin
            mul_a = mep_pkg::MUL_A_BITS'(y_dec);
            mul_b = mep_pkg::MUL_B_BITS'(y_dec);
         end
         mep_pkg::OP_R2_MA2Y: begin
            mul_a = mep_pkg::MUL_A_BITS'(a2_ff);
            mul_b = prod_ff[mep_pkg::MUL_B_BITS-1:0];
         end
         mep_pkg::OP_R2_MA2B2: begin
            mul_a = mep_pkg::MUL_A_BITS'(a2_ff);
            mul_b = mep_pkg::MUL_B_BITS'(b2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
      prod_in  = mul_full[mep_pkg::PROD_BITS-1:0];
   end

   // tx tracks b2*(2x+1) and ty tracks a2*(2y-1); every increment is built from them.
   always_comb begin
      a2_d   = signed'(DB'(a2_ff));
      b2_d   = signed'(DB'(b2_ff));
      prod_d = signed'(DB'(prod_ff));
      tx_d   = DB'(tx_ff);
      ty_d   = DB'(ty_ff);
      a2_t   = signed'(TB'(a2_ff));
      b2_t   = signed'(TB'(b2_ff));
      r1_dx  = (tx_d + (b2_d <<< 1)) <<< 2;
      r1_dy  = (a2_d - ty_d) <<< 2;
      r2_dx  = (tx_d + b2_d) <<< 2;
      r2_dy  = ((a2_d <<< 1) - ty_d) <<< 2;
      init_d = (b2_d <<< 2) - (prod_d <<< 2) + a2_d;
   end

   assign cnt_next = {1'b0, cnt_ff} + (mep_pkg::CNT_BITS+1)'(1);

   always_comb begin
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      a2_in       = a2_ff;
      b2_in       = b2_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      d_in        = d_ff;
      cnt_in      = cmd.emit ? cnt_next[mep_pkg::CNT_BITS-1:0] : cnt_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      unique case (cmd.op)
         mep_pkg::OP_LOAD: begin
            centre_x_in = cx_load + CB'(a_load);
            centre_y_in = cy_load + CB'(b_load);
            a_in        = a_load;
            b_in        = b_load;
            red_in      = req_tdata[30];
            green_in    = req_tdata[31];
         end
         mep_pkg::OP_MUL_BB: begin
            a2_in = prod_ff[mep_pkg::SQ_BITS-1:0];
         end
         mep_pkg::OP_MUL_A2B: begin
            b2_in = prod_ff[mep_pkg::SQ_BITS-1:0];
         end
         mep_pkg::OP_INIT: begin
            x_in   = '0;
            y_in   = mep_pkg::STEP_BITS'(b_ff);
            tx_in  = b2_t;
            ty_in  = signed'(TB'({prod_ff, 1'b0})) - a2_t;
            d_in   = init_d;
            cnt_in = '0;
         end
         mep_pkg::OP_R1_STEP: begin
            x_in  = x_ff + mep_pkg::STEP_BITS'(1);
            tx_in = tx_ff + (b2_t <<< 1);
            if (d_ff < 0) begin
               d_in = d_ff + r1_dx;
            end else begin
               d_in  = d_ff + r1_dx + r1_dy;
               y_in  = y_dec;
               ty_in = ty_ff - (a2_t <<< 1);
            end
         end
         mep_pkg::OP_R2_MY: begin
            d_in = prod_d;
         end
         mep_pkg::OP_R2_MA2B2: begin
            d_in = d_ff + (prod_d <<< 2);
         end
         mep_pkg::OP_R2_FIN: begin
            d_in = d_ff - (prod_d <<< 2);
         end
         mep_pkg::OP_R2_STEP: begin
            y_in  = y_dec;
            ty_in = ty_ff - (a2_t <<< 1);
            if (d_ff < 0) begin
               d_in  = d_ff + r2_dx + r2_dy;
               x_in  = x_ff + mep_pkg::STEP_BITS'(1);
               tx_in = tx_ff + (b2_t <<< 1);
            end else begin
               d_in = d_ff + r2_dy;
            end
         end
         default: begin
            d_in = d_ff;
         end
      endcase
   end

   always_comb begin
      status.zero_size = (req_w == '0) || (req_h == '0);
      status.r1_more   = (ty_ff > tx_ff) &&
                         (cnt_next < (mep_pkg::CNT_BITS+1)'(mep_pkg::MAX_RES));
      status.y_more    = (y_ff != '0) &&
                         (cnt_next < (mep_pkg::CNT_BITS+1)'(mep_pkg::MAX_RES));
      status.slot_free = !rsp_valid_ff || rsp_tready;
   end

   // The four mirrored points of the current step.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.emit) begin
         rsp_data_in = {6'b0, green_ff, red_ff,
                        centre_y_ff + CB'(y_ff),
                        centre_y_ff - CB'(y_ff),
                        centre_x_ff - CB'(x_ff),
                        centre_x_ff + CB'(x_ff)};
         rsp_last_in = cmd.last;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      centre_x_ff <= centre_x_in;
      centre_y_ff <= centre_y_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      a2_ff       <= a2_in;
      b2_ff       <= b2_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/mep_ctrl.sv */
// Controller state machine that sequences the setup, the two regions and the output.
`include "assert_macros.svh"

module mep_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mep_pkg::dp_status_type status,
   output mep_pkg::dp_cmd_type    cmd
);

   mep_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mep_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.op     = mep_pkg::OP_IDLE;
      cmd.emit   = 1'b0;
      cmd.last   = 1'b0;
      unique case (state_ff)
         mep_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = mep_pkg::OP_LOAD;
               // A zero size yields no points at all.
               if (!status.zero_size) begin
                  state_in = mep_pkg::S_SQ_A;
               end
            end
         end
         mep_pkg::S_SQ_A: begin
            cmd.op   = mep_pkg::OP_MUL_AA;
            state_in = mep_pkg::S_SQ_B;
         end
         mep_pkg::S_SQ_B: begin
            cmd.op   = mep_pkg::OP_MUL_BB;
            state_in = mep_pkg::S_A2B;
         end
         mep_pkg::S_A2B: begin
            cmd.op   = mep_pkg::OP_MUL_A2B;
            state_in = mep_pkg::S_INIT;
         end
         mep_pkg::S_INIT: begin
            cmd.op   = mep_pkg::OP_INIT;
            state_in = mep_pkg::S_R1;
         end
         mep_pkg::S_R1: begin
            if (!status.r1_more && status.y_more) begin
               // The last region-one point goes out from S_R2, which sends before it steps.
               state_in = mep_pkg::S_R2_MX;
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = !status.r1_more;
               if (status.r1_more) begin
                  cmd.op = mep_pkg::OP_R1_STEP;
               end else begin
                  state_in = mep_pkg::S_IDLE;
               end
            end
         end
         mep_pkg::S_R2_MX: begin
            cmd.op   = mep_pkg::OP_R2_MX;
            state_in = mep_pkg::S_R2_MY;
         end
         mep_pkg::S_R2_MY: begin
            cmd.op   = mep_pkg::OP_R2_MY;
            state_in = mep_pkg::S_R2_MA2Y;
         end
         mep_pkg::S_R2_MA2Y: begin
            cmd.op   = mep_pkg::OP_R2_MA2Y;
            state_in = mep_pkg::S_R2_MA2B2;
         end
         mep_pkg::S_R2_MA2B2: begin
            cmd.op   = mep_pkg::OP_R2_MA2B2;
            state_in = mep_pkg::S_R2_FIN;
         end
         mep_pkg::S_R2_FIN: begin
            cmd.op   = mep_pkg::OP_R2_FIN;
            state_in = mep_pkg::S_R2;
         end
         mep_pkg::S_R2: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = !status.y_more;
               if (status.y_more) begin
                  cmd.op = mep_pkg::OP_R2_STEP;
               end else begin
                  state_in = mep_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = mep_pkg::S_IDLE;
         end
      endcase
   end

   `MEP_ASSERT(a_emit_slot, clock, reset, cmd.emit |-> status.slot_free,
               "point emitted into a full output register")
   `MEP_ASSERT_NEXT(a_last_idle, clock, reset, cmd.emit && cmd.last,
                    state_ff == mep_pkg::S_IDLE, "controller not idle after the last point")
   `MEP_ASSERT(a_step_emit, clock, reset,
               (cmd.op == mep_pkg::OP_R1_STEP || cmd.op == mep_pkg::OP_R2_STEP) |-> cmd.emit,
               "walk advanced without emitting its point")

endmodule

/* hw/rtl/midpoint_ellipse_plotter.sv */
// The first point is registered out after the setup states S_SQ_A, S_SQ_B, S_A2B and S_INIT.
// Points follow one per cycle while the output is taken, except where the walk enters region two,
// which passes through S_R2_MX, S_R2_MY, S_R2_MA2Y, S_R2_MA2B2 and S_R2_FIN; the setup
// multiplies run in S_SQ_A, S_SQ_B and S_A2B before the first point.
// A command of zero size is taken and yields no point.
// Synchronous active-high reset idles the controller and empties the output register.
module midpoint_ellipse_plotter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // corner_x[7:0], corner_y[15:8], box_width[22:16], box_height[29:23],
   // red_on[30], green_on[31]
   input  logic [mep_pkg::REQ_BITS-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // x_plus[7:0], x_minus[15:8], y_minus[23:16], y_plus[31:24],
   // red_out[32], green_out[33], zero[39:34]
   output logic [mep_pkg::RSP_BITS-1:0]      rsp_tdata,
   output logic                              rsp_tlast
);

   mep_pkg::dp_cmd_type    cmd;
   mep_pkg::dp_status_type status;

   mep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mep_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
